@@ rtl/core/bcz_pkg.sv @@
// Shared constants and types for the cubic Bezier point evaluator.
`timescale 1ns / 1ps

package bcz_pkg;

	// Default parameter values
	localparam int STEPS_DEF      = 1024;
	localparam int COORD_BITS_DEF = 10;

	// Fixed field widths
	localparam int STEP_IDX_W = 11;
	localparam int CFG_IDX_W  = 4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P0_X = 4'd0,
		REG_P0_Y = 4'd1,
		REG_P1_X = 4'd2,
		REG_P1_Y = 4'd3,
		REG_P2_X = 4'd4,
		REG_P2_Y = 4'd5,
		REG_P3_X = 4'd6,
		REG_P3_Y = 4'd7
	} cfg_reg_t;

	// Stage advance enables for the blend stages
	typedef struct packed {
		logic en4;
		logic en5;
		logic en6;
	} pipe_en_t;

endpackage

@@ rtl/core/bcz_blend.sv @@
// Weighted sum and round-half-up of one coordinate, pipeline stages four to six.
`timescale 1ns / 1ps

module bcz_blend
	import bcz_pkg::*;
#(
	parameter int STEPS      = STEPS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                             clk,
	input  pipe_en_t                         pipe_en,
	input  logic [3*$clog2(STEPS):0]         w0,
	input  logic [3*$clog2(STEPS):0]         w1,
	input  logic [3*$clog2(STEPS):0]         w2,
	input  logic [3*$clog2(STEPS):0]         w3,
	input  logic [COORD_BITS-1:0]            c0,
	input  logic [COORD_BITS-1:0]            c1,
	input  logic [COORD_BITS-1:0]            c2,
	input  logic [COORD_BITS-1:0]            c3,
	output logic [COORD_BITS-1:0]            coord
);

	localparam int LB = $clog2(STEPS);
	localparam int FB = 3 * LB;
	localparam int WW = FB + 1;
	localparam int PW = WW + COORD_BITS;
	localparam int SW = PW + 1;
	localparam logic [SW:0] HALF = (SW+1)'(1) << (FB - 1);

	logic [PW-1:0] p0_s4, p1_s4, p2_s4, p3_s4;
	logic [SW-1:0] a_s5, b_s5;
	logic [SW:0]   tot;
	logic [COORD_BITS-1:0] coord_s6;

	// Stage 4: one product per weight
	always_ff @(posedge clk) begin
		if (pipe_en.en4) begin
			p0_s4 <= PW'(w0) * PW'(c0);
			p1_s4 <= PW'(w1) * PW'(c1);
			p2_s4 <= PW'(w2) * PW'(c2);
			p3_s4 <= PW'(w3) * PW'(c3);
		end
	end

	// Stage 5: pair sums
	always_ff @(posedge clk) begin
		if (pipe_en.en5) begin
			a_s5 <= SW'(p0_s4) + SW'(p1_s4);
			b_s5 <= SW'(p2_s4) + SW'(p3_s4);
		end
	end

	// Stage 6: final sum, add half, drop the fraction bits
	assign tot = (SW+1)'(a_s5) + (SW+1)'(b_s5) + HALF;

	always_ff @(posedge clk) begin
		if (pipe_en.en6) begin
			coord_s6 <= tot[FB +: COORD_BITS];
		end
	end

	assign coord = coord_s6;

endmodule

@@ rtl/core/cubic_bezier_point_eval.sv @@
// Top level of the cubic Bezier point evaluator: config registers, weight stages, handshake.
`timescale 1ns / 1ps

// Evaluates a cubic Bezier curve at t = step_index / STEPS and returns the point rounded half
// up to whole pixels. The four control points are written through the configuration port
// (index 0..7 = p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y; other indexes are dropped) and
// must be written while no request is in flight. A step index above STEPS is treated as STEPS,
// so it yields the end point p3. While out_ready stays high, the block accepts one request
// per clock and delivers one point per clock. The six register stages are: saturate and
// form 1-t and 3t, the squares and 3t(1-t), the four Bernstein weights (exact,
// 3*log2(STEPS) fraction bits), the weight-times-coordinate products, pair sums, and the
// final sum with rounding, which is also the output register. A stall at the output holds
// each stage that is occupied and lets empty stages keep filling, so a bubble in the stream
// is squeezed out before in_ready drops. STEPS must be a power of two.
module cubic_bezier_point_eval
	import bcz_pkg::*;
#(
	parameter int STEPS      = STEPS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [STEP_IDX_W-1:0] step_index,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y
);

	localparam int LB = $clog2(STEPS);
	localparam int IW = LB + 1;                 // holds 0..STEPS
	localparam int FB = 3 * LB;                 // fraction bits of a weight
	localparam int WW = FB + 1;                 // weight width
	localparam int CW = (IW > STEP_IDX_W) ? IW : STEP_IDX_W;
	localparam logic [CW-1:0] STEPS_C = CW'(STEPS);
	localparam logic [IW-1:0] STEPS_I = IW'(STEPS);

	// control point registers
	logic [COORD_BITS-1:0] p0_x_q, p0_y_q, p1_x_q, p1_y_q;
	logic [COORD_BITS-1:0] p2_x_q, p2_y_q, p3_x_q, p3_y_q;

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	pipe_en_t blend_en;

	// datapath
	logic [CW-1:0]     idx_ext;
	logic [IW-1:0]     i_sat;
	logic [IW-1:0]     i_s1, u_s1;
	logic [IW+1:0]     i3_s1;
	logic [IW-1:0]     i_s2, u_s2;
	logic [2*IW-1:0]   u2_s2, i2_s2;
	logic [2*IW+1:0]   iu3_s2;
	logic [3*IW-1:0]   w0_full, w3_full;
	logic [3*IW+1:0]   w1_full, w2_full;
	logic [WW-1:0]     w0_s3, w1_s3, w2_s3, w3_s3;

	// Write a control point; drop indexes past the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_x_q <= '0;
			p0_y_q <= '0;
			p1_x_q <= '0;
			p1_y_q <= '0;
			p2_x_q <= '0;
			p2_y_q <= '0;
			p3_x_q <= '0;
			p3_y_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_P0_X: p0_x_q <= cfg_data;
				REG_P0_Y: p0_y_q <= cfg_data;
				REG_P1_X: p1_x_q <= cfg_data;
				REG_P1_Y: p1_y_q <= cfg_data;
				REG_P2_X: p2_x_q <= cfg_data;
				REG_P2_Y: p2_y_q <= cfg_data;
				REG_P3_X: p3_x_q <= cfg_data;
				REG_P3_Y: p3_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A stage advances when it is empty or the next one advances.
	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_ready  = en1;
	assign out_valid = v_s6;

	assign blend_en.en4 = en4;
	assign blend_en.en5 = en5;
	assign blend_en.en6 = en6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: saturate the index to STEPS, form u = STEPS - i and 3i.
	assign idx_ext = CW'(step_index);
	assign i_sat   = (idx_ext > STEPS_C) ? STEPS_I : idx_ext[IW-1:0];

	always_ff @(posedge clk) begin
		if (en1) begin
			i_s1  <= i_sat;
			u_s1  <= STEPS_I - i_sat;
			i3_s1 <= (IW+2)'(i_sat) + ((IW+2)'(i_sat) << 1);
		end
	end

	// Stage 2: squares and 3iu.
	always_ff @(posedge clk) begin
		if (en2) begin
			i_s2   <= i_s1;
			u_s2   <= u_s1;
			u2_s2  <= (2*IW)'(u_s1) * (2*IW)'(u_s1);
			i2_s2  <= (2*IW)'(i_s1) * (2*IW)'(i_s1);
			iu3_s2 <= (2*IW+2)'(i3_s1) * (2*IW+2)'(u_s1);
		end
	end

	// Stage 3: Bernstein weights; each fits WW bits since they sum to STEPS^3.
	assign w0_full = (3*IW)'(u2_s2) * (3*IW)'(u_s2);
	assign w1_full = (3*IW+2)'(iu3_s2) * (3*IW+2)'(u_s2);
	assign w2_full = (3*IW+2)'(iu3_s2) * (3*IW+2)'(i_s2);
	assign w3_full = (3*IW)'(i2_s2) * (3*IW)'(i_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			w0_s3 <= w0_full[WW-1:0];
			w1_s3 <= w1_full[WW-1:0];
			w2_s3 <= w2_full[WW-1:0];
			w3_s3 <= w3_full[WW-1:0];
		end
	end

	// Stages 4 to 6, one blend per axis.
	bcz_blend #(
		.STEPS      (STEPS),
		.COORD_BITS (COORD_BITS)
	) u_blend_x (
		.clk     (clk),
		.pipe_en (blend_en),
		.w0      (w0_s3),
		.w1      (w1_s3),
		.w2      (w2_s3),
		.w3      (w3_s3),
		.c0      (p0_x_q),
		.c1      (p1_x_q),
		.c2      (p2_x_q),
		.c3      (p3_x_q),
		.coord   (pixel_x)
	);

	bcz_blend #(
		.STEPS      (STEPS),
		.COORD_BITS (COORD_BITS)
	) u_blend_y (
		.clk     (clk),
		.pipe_en (blend_en),
		.w0      (w0_s3),
		.w1      (w1_s3),
		.w2      (w2_s3),
		.w3      (w3_s3),
		.c0      (p0_y_q),
		.c1      (p1_y_q),
		.c2      (p2_y_q),
		.c3      (p3_y_q),
		.coord   (pixel_y)
	);

`ifndef SYNTHESIS
	localparam logic [WW+1:0] DEN = (WW+2)'(1) << FB;

	// An accepted request lands in stage 1.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request missing from stage 1");

	// A stalled stage 1 keeps its item.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en2 |=> v_s1 && $stable(i_s1))
		else $error("stage 1 item lost during stall");

	// t and 1-t add up to one.
	a_tu_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (i_s1 + u_s1) == STEPS_I)
		else $error("stage 1 index and complement disagree");

	// The weights form a partition of unity.
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> ((WW+2)'(w0_s3) + (WW+2)'(w1_s3) + (WW+2)'(w2_s3)
			+ (WW+2)'(w3_s3)) == DEN)
		else $error("Bernstein weights do not sum to STEPS cubed");
`endif

endmodule
